FILE: rtl/blc_pkg.sv
// blc_pkg: shared types, kind codes and keyword tables of the batch line classifier
// no dependencies; imported by every rtl file of the block but blc_stream_ifs
package blc_pkg;

	localparam int TEXT_DEPTH = 63;
	localparam int TEXT_AW    = 6;

	// result kinds
	localparam logic [3:0] KIND_BLANK    = 4'd0;
	localparam logic [3:0] KIND_LABEL    = 4'd1;
	localparam logic [3:0] KIND_REM      = 4'd2;
	localparam logic [3:0] KIND_ECHO_OFF = 4'd3;
	localparam logic [3:0] KIND_ECHO_ON  = 4'd4;
	localparam logic [3:0] KIND_ECHO     = 4'd5;
	localparam logic [3:0] KIND_GOTO     = 4'd6;
	localparam logic [3:0] KIND_IF       = 4'd7;
	localparam logic [3:0] KIND_FOR      = 4'd8;
	localparam logic [3:0] KIND_SHIFT    = 4'd9;
	localparam logic [3:0] KIND_CALL     = 4'd10;
	localparam logic [3:0] KIND_PAUSE    = 4'd11;
	localparam logic [3:0] KIND_COMMAND  = 4'd12;

	// keyword slots
	localparam logic [2:0] KW_REM   = 3'd0;
	localparam logic [2:0] KW_ECHO  = 3'd1;
	localparam logic [2:0] KW_GOTO  = 3'd2;
	localparam logic [2:0] KW_IF    = 3'd3;
	localparam logic [2:0] KW_FOR   = 3'd4;
	localparam logic [2:0] KW_SHIFT = 3'd5;
	localparam logic [2:0] KW_CALL  = 3'd6;
	localparam logic [2:0] KW_PAUSE = 3'd7;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_AT    = 8'h40;

	typedef struct packed {
		logic                 start;
		logic [3:0]           kind;
		logic                 at;
		logic [TEXT_AW-1:0]   len;
	} blc_flush_req_t;

	typedef struct packed {
		logic                 en;
		logic [TEXT_AW-1:0]   addr;
		logic [7:0]           data;
	} blc_wr_t;

	typedef struct packed {
		logic                 en;
		logic [TEXT_AW-1:0]   addr;
	} blc_rd_t;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A]}) ? c - 8'h20 : c;
	endfunction

	function automatic logic is_gap(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic [2:0] kw_len(input logic [2:0] idx);
		logic [2:0] n;
		case (idx)
			KW_REM:   n = 3'd3;
			KW_ECHO:  n = 3'd4;
			KW_GOTO:  n = 3'd4;
			KW_IF:    n = 3'd2;
			KW_FOR:   n = 3'd3;
			KW_SHIFT: n = 3'd5;
			KW_CALL:  n = 3'd4;
			KW_PAUSE: n = 3'd5;
			default:  n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] kw_kind(input logic [2:0] idx);
		logic [3:0] k;
		case (idx)
			KW_REM:   k = KIND_REM;
			KW_ECHO:  k = KIND_ECHO;
			KW_GOTO:  k = KIND_GOTO;
			KW_IF:    k = KIND_IF;
			KW_FOR:   k = KIND_FOR;
			KW_SHIFT: k = KIND_SHIFT;
			KW_CALL:  k = KIND_CALL;
			KW_PAUSE: k = KIND_PAUSE;
			default:  k = KIND_COMMAND;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] idx, input logic [2:0] pos);
		logic [39:0] word;
		logic [7:0]  c;
		case (idx)
			KW_REM:   word = {"REM", 16'h0};
			KW_ECHO:  word = {"ECHO", 8'h0};
			KW_GOTO:  word = {"GOTO", 8'h0};
			KW_IF:    word = {"IF", 24'h0};
			KW_FOR:   word = {"FOR", 16'h0};
			KW_SHIFT: word = "SHIFT";
			KW_CALL:  word = {"CALL", 8'h0};
			KW_PAUSE: word = "PAUSE";
			default:  word = 40'h0;
		endcase
		case (pos)
			3'd0:    c = word[39:32];
			3'd1:    c = word[31:24];
			3'd2:    c = word[23:16];
			3'd3:    c = word[15:8];
			3'd4:    c = word[7:0];
			default: c = 8'h0;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/blc_stream_ifs.sv
// blc_in_if and blc_out_if: valid/ready channels of the batch line classifier
// depends on nothing
interface blc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);
endinterface

interface blc_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] kind;
	logic       suppressed;
	logic [7:0] text_char;
	logic       text_valid;
	logic       last_of_run;

	modport source (output valid, output kind, output suppressed, output text_char,
		output text_valid, output last_of_run, input ready);
	modport sink   (input valid, input kind, input suppressed, input text_char,
		input text_valid, input last_of_run, output ready);
endinterface

FILE: rtl/blc_text_mem.sv
// blc_text_mem: captured text store, one write port, one registered read port
// depends on blc_pkg
module blc_text_mem (
	input  logic              clk,
	input  blc_pkg::blc_wr_t  wr,
	input  blc_pkg::blc_rd_t  rd,
	output logic [7:0]        rdata
);
	import blc_pkg::*;

	logic [7:0] mem [TEXT_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end
endmodule

FILE: rtl/blc_parser.sv
// blc_parser: per-character line scanner, keyword match, text capture into the store
// depends on blc_pkg; writes blc_text_mem, hands finished lines to blc_flush
module blc_parser #(
	parameter int LINE_MAX  = 64,
	parameter int LABEL_MAX = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [7:0]              ch,
	output blc_pkg::blc_wr_t        wr,
	output blc_pkg::blc_flush_req_t req
);
	import blc_pkg::*;

	localparam logic [TEXT_AW-1:0] ECHO_CAP  = TEXT_AW'(LINE_MAX - 1);
	localparam logic [TEXT_AW-1:0] LABEL_CAP = TEXT_AW'(LABEL_MAX - 1);

	typedef enum logic [3:0] {
		PH_LEAD, PH_AFTER_AT, PH_KEYWORD, PH_LABEL, PH_ECHO_GAP,
		PH_ECHO_TEXT, PH_GOTO_GAP, PH_GOTO_NAME, PH_COMMAND, PH_DECIDED
	} phase_t;

	phase_t             phase_q, phase_d;
	logic               at_q, at_d;
	logic [7:0]         alive_q, alive_d;
	logic [2:0]         pos_q, pos_d;
	logic [1:0]         onoff_q, onoff_d;
	logic [TEXT_AW-1:0] len_q, len_d;
	logic               stopped_q, stopped_d;

	logic [7:0]         uc;
	logic               gap;
	logic [7:0]         alive_upd;
	logic               match_found;
	logic [2:0]         match_idx;
	logic [2:0]         pos_inc;
	logic [2:0]         echo_pos;
	logic [1:0]         echo_base;
	logic               do_kw, do_label, do_echo;
	logic [3:0]         fin_kind;
	logic               fin_text;

	assign uc      = to_upper(ch);
	assign gap     = is_gap(ch);
	assign pos_inc = (pos_q < 3'd7) ? pos_q + 3'd1 : pos_q;

	// per-keyword survival and full match at the current position
	always_comb begin
		match_found = 1'b0;
		match_idx   = '0;
		for (int i = 7; i >= 0; i--) begin
			alive_upd[i] = alive_q[i] && (pos_q < kw_len(3'(i))) && (pos_q < 3'd5)
				&& (uc == kw_char(3'(i), pos_q));
			if (alive_q[i] && kw_len(3'(i)) == pos_q) begin
				match_found = 1'b1;
				match_idx   = 3'(i);
			end
		end
	end

	assign echo_pos  = (phase_q == PH_ECHO_GAP) ? 3'd0 : pos_q;
	assign echo_base = (phase_q == PH_ECHO_GAP) ? 2'b11 : onoff_q;

	// kind at end of line
	always_comb begin
		fin_text = 1'b0;
		case (phase_q)
			PH_LEAD, PH_AFTER_AT: fin_kind = KIND_BLANK;
			PH_KEYWORD:   fin_kind = match_found ? kw_kind(match_idx) : KIND_COMMAND;
			PH_LABEL: begin
				fin_kind = KIND_LABEL;
				fin_text = 1'b1;
			end
			PH_ECHO_GAP:  fin_kind = KIND_ECHO;
			PH_ECHO_TEXT: begin
				if (onoff_q[0] && pos_q == 3'd3) begin
					fin_kind = KIND_ECHO_OFF;
				end else if (onoff_q[1] && pos_q == 3'd2) begin
					fin_kind = KIND_ECHO_ON;
				end else begin
					fin_kind = KIND_ECHO;
					fin_text = 1'b1;
				end
			end
			PH_GOTO_GAP:  fin_kind = KIND_GOTO;
			PH_GOTO_NAME: begin
				fin_kind = KIND_GOTO;
				fin_text = 1'b1;
			end
			PH_DECIDED:   fin_kind = kw_kind(pos_q);
			default:      fin_kind = KIND_COMMAND;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		at_d      = at_q;
		alive_d   = alive_q;
		pos_d     = pos_q;
		onoff_d   = onoff_q;
		len_d     = len_q;
		stopped_d = stopped_q;
		do_kw     = 1'b0;
		do_label  = 1'b0;
		do_echo   = 1'b0;
		wr.en     = 1'b0;
		wr.addr   = len_q;
		wr.data   = ch;
		req.start = 1'b0;
		req.kind  = fin_kind;
		req.at    = at_q;
		req.len   = fin_text ? len_q : '0;

		if (take && ch != CH_NUL) begin
			case (phase_q)
				PH_LEAD, PH_AFTER_AT: begin
					if (!gap) begin
						if (phase_q == PH_LEAD && ch == CH_AT) begin
							at_d    = 1'b1;
							phase_d = PH_AFTER_AT;
						end else if (ch == CH_COLON) begin
							phase_d = PH_LABEL;
						end else begin
							phase_d = PH_KEYWORD;
							do_kw   = 1'b1;
						end
					end
				end
				PH_KEYWORD: do_kw = 1'b1;
				PH_LABEL, PH_GOTO_NAME: do_label = 1'b1;
				PH_ECHO_GAP: begin
					if (!gap) begin
						phase_d = PH_ECHO_TEXT;
						do_echo = 1'b1;
					end
				end
				PH_ECHO_TEXT: do_echo = 1'b1;
				PH_GOTO_GAP: begin
					if (!gap) begin
						phase_d  = PH_GOTO_NAME;
						do_label = (ch != CH_COLON);
					end
				end
				default: ;
			endcase

			if (do_kw) begin
				if (gap) begin
					if (!match_found) begin
						phase_d = PH_COMMAND;
					end else if (match_idx == KW_ECHO) begin
						phase_d = PH_ECHO_GAP;
						pos_d   = '0;
					end else if (match_idx == KW_GOTO) begin
						phase_d = PH_GOTO_GAP;
					end else begin
						phase_d = PH_DECIDED;
						pos_d   = match_idx;
					end
				end else begin
					alive_d = alive_upd;
					pos_d   = pos_inc;
					if (alive_upd == '0) begin
						phase_d = PH_COMMAND;
					end
				end
			end

			if (do_label && !stopped_q) begin
				if (gap || ch == CH_COLON) begin
					stopped_d = 1'b1;
				end else if (len_q < LABEL_CAP) begin
					wr.en = 1'b1;
					len_d = len_q + 1'b1;
				end
			end

			if (do_echo) begin
				onoff_d[0] = echo_base[0] && (echo_pos < 3'd3)
					&& (uc == ((echo_pos == 3'd0) ? "O" : "F"));
				onoff_d[1] = echo_base[1] && (echo_pos < 3'd2)
					&& (uc == ((echo_pos == 3'd0) ? "O" : "N"));
				pos_d = (echo_pos < 3'd7) ? echo_pos + 3'd1 : echo_pos;
				if (len_q < ECHO_CAP) begin
					wr.en = 1'b1;
					len_d = len_q + 1'b1;
				end
			end
		end else if (take) begin
			req.start = 1'b1;
			phase_d   = PH_LEAD;
			at_d      = 1'b0;
			alive_d   = '1;
			pos_d     = '0;
			onoff_d   = '0;
			len_d     = '0;
			stopped_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEAD;
			at_q      <= 1'b0;
			alive_q   <= '1;
			pos_q     <= '0;
			onoff_q   <= '0;
			len_q     <= '0;
			stopped_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			at_q      <= at_d;
			alive_q   <= alive_d;
			pos_q     <= pos_d;
			onoff_q   <= onoff_d;
			len_q     <= len_d;
			stopped_q <= stopped_d;
		end
	end
endmodule

FILE: rtl/blc_flush.sv
// blc_flush: end-of-line sequencer, reads the text store and drives the result register
// depends on blc_pkg, blc_out_if; reads blc_text_mem
module blc_flush (
	input  logic                    clk,
	input  logic                    arst_n,
	input  blc_pkg::blc_flush_req_t req,
	output logic                    busy,
	output blc_pkg::blc_rd_t        rd,
	input  logic [7:0]              rdata,
	blc_out_if.source               results
);
	import blc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SINGLE, ST_RUN} state_t;

	state_t             state_q;
	logic [3:0]         kind_q;
	logic               at_q;
	logic [TEXT_AW-1:0] n_q;
	logic [TEXT_AW-1:0] idx_q;
	logic               pend_q;
	logic               pend_last_q;
	logic               out_valid_q;
	logic               slot_free;
	logic               load;
	logic               emit;

	assign slot_free = !out_valid_q || results.ready;
	assign load      = (state_q == ST_RUN) && pend_q && slot_free;
	assign emit      = load || ((state_q == ST_SINGLE) && slot_free);
	assign rd.en     = (state_q == ST_RUN) && (idx_q != n_q) && (!pend_q || load);
	assign rd.addr   = idx_q;
	assign busy      = (state_q != ST_IDLE);

	assign results.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						kind_q  <= req.kind;
						at_q    <= req.at;
						n_q     <= req.len;
						idx_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= (req.len == '0) ? ST_SINGLE : ST_RUN;
					end
				end
				ST_SINGLE: begin
					if (slot_free) begin
						results.kind        <= kind_q;
						results.suppressed  <= at_q;
						results.text_char   <= '0;
						results.text_valid  <= 1'b0;
						results.last_of_run <= 1'b1;
						state_q             <= ST_IDLE;
					end
				end
				ST_RUN: begin
					if (load) begin
						results.kind        <= kind_q;
						results.suppressed  <= at_q;
						results.text_char   <= rdata;
						results.text_valid  <= 1'b1;
						results.last_of_run <= pend_last_q;
						if (pend_last_q) begin
							state_q <= ST_IDLE;
						end
					end
					if (rd.en) begin
						idx_q       <= idx_q + 1'b1;
						pend_last_q <= (idx_q + 1'b1 == n_q);
						pend_q      <= 1'b1;
					end else if (load) begin
						pend_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/batch_line_classifier_top.sv
// batch_line_classifier_top: top level of the batch line classifier
// depends on blc_pkg, blc_stream_ifs, blc_parser, blc_text_mem, blc_flush
//
// usage
// - chars: one line character per word; a zero character ends the line
// - results: per line, one word carrying kind and the '@' flag, or, when a
//   label name, goto target or echo text was captured, one word per captured
//   character; last_of_run marks the final word of the line
// - a non-zero character is absorbed by the scanner and gives no word
// - throughput: one character per cycle while a line is scanned
// - end of line: a line with no text has its word registered once the result
//   register is free after the zero is taken; with n captured characters the
//   store is read first and the first word is registered from the read data,
//   then one word per cycle while results.ready stays high
// - chars.ready is low from the zero until the last word of the line sits in
//   the result register; the pace is set by the single read port of the text
//   store
// - a stalled receiver holds the result register; the store read waits, and
//   the next line may start once the final word is registered
// - reset: scanner returns to the leading-whitespace phase with the '@' flag
//   and counters cleared and the keyword mask set to all ones; the text store
//   is not cleared, it is only read below the captured length
module batch_line_classifier_top #(
	parameter int LINE_MAX  = 64,
	parameter int LABEL_MAX = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	blc_in_if.sink    chars,
	blc_out_if.source results
);
	import blc_pkg::*;

	blc_wr_t        wr;
	blc_rd_t        rd;
	blc_flush_req_t req;
	logic [7:0]     rdata;
	logic           busy;
	logic           take;

	// the scanner is held off while a finished line is being read out
	assign chars.ready = !busy;
	assign take        = chars.valid && chars.ready;

	blc_parser #(
		.LINE_MAX  (LINE_MAX),
		.LABEL_MAX (LABEL_MAX)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.ch     (chars.ch),
		.wr     (wr),
		.req    (req)
	);

	blc_text_mem u_mem (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	blc_flush u_flush (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.busy    (busy),
		.rd      (rd),
		.rdata   (rdata),
		.results (results)
	);
endmodule

FILE: tb/testbench.sv
// testbench for the batch line classifier: directed lines from a table, then random lines
// depends on blc_pkg, blc_stream_ifs and batch_line_classifier_top
`timescale 1ns / 1ps

module testbench;
	import blc_pkg::*;

	localparam int LINE_MAX      = 64;
	localparam int LABEL_MAX     = 16;
	localparam int ECHO_KEEP     = LINE_MAX - 1;
	localparam int NAME_KEEP     = LABEL_MAX - 1;
	localparam int RANDOM_CHARS  = 40;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_CYCLES  = 20;
	localparam int LIMIT_NS      = 3_000_000;
	localparam int DIR_ROWS      = 20;

	// directed row whose result words come from the predictor
	localparam int PREDICTED = -1;
	localparam int NO_SLOT   = -1;

	typedef enum logic [3:0] {
		SCAN_LEAD, SCAN_AFTER_AT, SCAN_WORD, SCAN_LABEL, SCAN_ECHO_GAP,
		SCAN_ECHO_TEXT, SCAN_GOTO_GAP, SCAN_GOTO_NAME, SCAN_COMMAND, SCAN_DECIDED
	} scan_phase_t;

	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TICK} rx_mode_t;

	typedef struct packed {
		logic [3:0] kind;
		logic       at;
		logic [7:0] tchar;
		logic       tvalid;
		logic       last;
	} line_word_t;

	logic clk = 1'b0;
	logic arst_n;

	blc_in_if  chars ();
	blc_out_if results ();

	batch_line_classifier_top #(
		.LINE_MAX (LINE_MAX),
		.LABEL_MAX(LABEL_MAX)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.results(results)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// words still owed by the block, oldest first
	line_word_t expected_words [$];
	// characters of the line about to be sent, without the closing zero
	logic [7:0] line_buf [$];

	int mismatches    = 0;
	int words_checked = 0;
	int chars_sent    = 0;
	int lines_sent    = 0;
	int burst_left    = 0;
	logic [15:0] kinds_seen = '0;

	// long receiver hold-off: requested by the stimulus, timed by the receiver
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int rx_mode_left  = 0;

	// ---------------------------------------------------------------
	// line scanner shadow: phase, '@' flag, keyword tracking, captured text
	// ---------------------------------------------------------------
	scan_phase_t scan;
	logic       at_seen;
	logic [7:0] alive;
	logic [2:0] match_pos;
	logic [2:0] decided_slot;
	logic [1:0] off_on_live;
	logic [7:0] name_store [0:TEXT_DEPTH-1];
	int         name_len;
	logic       name_stopped;

	function automatic string kw_spelling(input int slot);
		case (slot)
			KW_REM:   return "REM";
			KW_ECHO:  return "ECHO";
			KW_GOTO:  return "GOTO";
			KW_IF:    return "IF";
			KW_FOR:   return "FOR";
			KW_SHIFT: return "SHIFT";
			KW_CALL:  return "CALL";
			default:  return "PAUSE";
		endcase
	endfunction

	function automatic logic [3:0] slot_kind(input int slot);
		case (slot)
			KW_REM:   return KIND_REM;
			KW_ECHO:  return KIND_ECHO;
			KW_GOTO:  return KIND_GOTO;
			KW_IF:    return KIND_IF;
			KW_FOR:   return KIND_FOR;
			KW_SHIFT: return KIND_SHIFT;
			KW_CALL:  return KIND_CALL;
			default:  return KIND_PAUSE;
		endcase
	endfunction

	// only a-z fold to upper case
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? (c & 8'hDF) : c;
	endfunction

	function automatic logic gap_or_tab(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic void clear_scan();
		scan         = SCAN_LEAD;
		at_seen      = 1'b0;
		alive        = 8'hFF;
		match_pos    = 3'd0;
		decided_slot = 3'd0;
		off_on_live  = 2'b00;
		name_len     = 0;
		name_stopped = 1'b0;
	endfunction

	function automatic void keep_char(input logic [7:0] c, input int cap);
		if (name_len < cap && name_len < TEXT_DEPTH) begin
			name_store[name_len] = c;
			name_len++;
		end
	endfunction

	// first keyword still alive whose length equals the characters seen
	function automatic int full_slot();
		int i;
		string s;
		for (i = 0; i < 8; i++) begin
			s = kw_spelling(i);
			if (alive[i] && s.len() == match_pos)
				return i;
		end
		return NO_SLOT;
	endfunction

	function automatic void word_char(input logic [7:0] c);
		int i;
		int slot;
		string s;
		if (gap_or_tab(c)) begin
			slot = full_slot();
			if (slot == NO_SLOT) begin
				scan = SCAN_COMMAND;
			end else if (slot == KW_ECHO) begin
				scan = SCAN_ECHO_GAP;
				match_pos = 3'd0;
			end else if (slot == KW_GOTO) begin
				scan = SCAN_GOTO_GAP;
			end else begin
				scan = SCAN_DECIDED;
				decided_slot = slot[2:0];
			end
			return;
		end
		for (i = 0; i < 8; i++) begin
			s = kw_spelling(i);
			if (!(match_pos < s.len() && fold_case(c) == s[match_pos]))
				alive[i] = 1'b0;
		end
		if (match_pos < 3'd7)
			match_pos++;
		if (alive == 8'h00)
			scan = SCAN_COMMAND;
	endfunction

	function automatic void open_word(input logic [7:0] c);
		if (c == CH_COLON) begin
			scan = SCAN_LABEL;
		end else begin
			scan = SCAN_WORD;
			alive = 8'hFF;
			match_pos = 3'd0;
			word_char(c);
		end
	endfunction

	// label name or goto target: stops at a gap or a colon
	function automatic void name_char(input logic [7:0] c);
		if (name_stopped)
			return;
		if (gap_or_tab(c) || c == CH_COLON) begin
			name_stopped = 1'b1;
			return;
		end
		keep_char(c, NAME_KEEP);
	endfunction

	// echo text is kept verbatim while OFF and ON are tracked alongside
	function automatic void echo_char(input logic [7:0] c);
		string off_word;
		string on_word;
		off_word = "OFF";
		on_word  = "ON";
		if (!(match_pos < 3 && fold_case(c) == off_word[match_pos]))
			off_on_live[0] = 1'b0;
		if (!(match_pos < 2 && fold_case(c) == on_word[match_pos]))
			off_on_live[1] = 1'b0;
		if (match_pos < 3'd7)
			match_pos++;
		keep_char(c, ECHO_KEEP);
	endfunction

	function automatic void close_line();
		logic [3:0] kind;
		logic       with_text;
		int         slot;
		int         n;
		int         i;
		line_word_t w;
		with_text = 1'b0;
		case (scan)
			SCAN_LEAD, SCAN_AFTER_AT: kind = KIND_BLANK;
			SCAN_WORD: begin
				slot = full_slot();
				kind = (slot == NO_SLOT) ? KIND_COMMAND : slot_kind(slot);
			end
			SCAN_LABEL: begin
				kind = KIND_LABEL;
				with_text = 1'b1;
			end
			SCAN_ECHO_GAP: kind = KIND_ECHO;
			SCAN_ECHO_TEXT: begin
				if (off_on_live[0] && match_pos == 3'd3) begin
					kind = KIND_ECHO_OFF;
				end else if (off_on_live[1] && match_pos == 3'd2) begin
					kind = KIND_ECHO_ON;
				end else begin
					kind = KIND_ECHO;
					with_text = 1'b1;
				end
			end
			SCAN_GOTO_GAP: kind = KIND_GOTO;
			SCAN_GOTO_NAME: begin
				kind = KIND_GOTO;
				with_text = 1'b1;
			end
			SCAN_DECIDED: kind = slot_kind(decided_slot);
			default: kind = KIND_COMMAND;
		endcase
		n = with_text ? name_len : 0;
		w.kind = kind;
		w.at   = at_seen;
		if (n == 0) begin
			w.tchar  = 8'h00;
			w.tvalid = 1'b0;
			w.last   = 1'b1;
			expected_words.push_back(w);
		end
		for (i = 0; i < n; i++) begin
			w.tchar  = name_store[i];
			w.tvalid = 1'b1;
			w.last   = (i == n - 1);
			expected_words.push_back(w);
		end
		clear_scan();
	endfunction

	// advance the shadow scanner by one accepted character
	function automatic void scan_char(input logic [7:0] c);
		if (c == CH_NUL) begin
			close_line();
			return;
		end
		case (scan)
			SCAN_LEAD: begin
				if (c == CH_AT) begin
					at_seen = 1'b1;
					scan = SCAN_AFTER_AT;
				end else if (!gap_or_tab(c)) begin
					open_word(c);
				end
			end
			SCAN_AFTER_AT: if (!gap_or_tab(c)) open_word(c);
			SCAN_WORD: word_char(c);
			SCAN_LABEL, SCAN_GOTO_NAME: name_char(c);
			SCAN_ECHO_GAP: begin
				if (!gap_or_tab(c)) begin
					scan = SCAN_ECHO_TEXT;
					off_on_live = 2'b11;
					match_pos = 3'd0;
					echo_char(c);
				end
			end
			SCAN_ECHO_TEXT: echo_char(c);
			SCAN_GOTO_GAP: begin
				if (!gap_or_tab(c)) begin
					scan = SCAN_GOTO_NAME;
					// one leading colon of the target is dropped
					if (c != CH_COLON)
						name_char(c);
				end
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// directed lines; a kind is typed in only where it is plain to see
	// ---------------------------------------------------------------
	string dir_text [DIR_ROWS] = '{
		"",
		"\t@ \t",
		":",
		":go here",
		"@:abcdefghijklmnop",
		"rEm x",
		"ECHO OFF",
		"@echo \ton",
		"echo \t ",
		"echo offx",
		"echo a :b\tc",
		"echo The quick brown fox jumps over the lazy dog; pack my box with five",
		"goto :a",
		"GOTO ::x",
		"goto abcdefghijklmnop",
		"if a",
		"shift\t",
		"pause",
		"@@echo off",
		"\377\200@"
	};

	int dir_kind [DIR_ROWS] = '{
		KIND_BLANK, KIND_BLANK, KIND_LABEL, PREDICTED, PREDICTED,
		KIND_REM, KIND_ECHO_OFF, KIND_ECHO_ON, KIND_ECHO, PREDICTED,
		PREDICTED, PREDICTED, PREDICTED, KIND_GOTO, PREDICTED,
		PREDICTED, PREDICTED, PREDICTED, KIND_COMMAND, KIND_COMMAND
	};

	bit dir_at [DIR_ROWS] = '{
		0, 1, 0, 0, 0,
		0, 0, 1, 0, 0,
		0, 0, 0, 0, 0,
		0, 0, 0, 1, 0
	};

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------

	// offer one character and wait for it to be taken; gaps fall between bursts,
	// except while the receiver is in its long hold-off so the block fills up
	task automatic send_char(input logic [7:0] c);
		if (burst_left == 0 && hold_left == 0) begin
			chars.valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 4)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		chars.valid <= 1'b1;
		chars.ch    <= c;
		@(posedge clk);
		while (!chars.ready)
			@(posedge clk);
		// word taken at this edge
		if (burst_left != 0)
			burst_left--;
		chars_sent++;
		scan_char(c);
	endtask

	// send line_buf and its closing zero; a typed-in word replaces the
	// single word predicted for the line
	task automatic send_line(input int typed_kind, input bit typed_at);
		int i;
		line_word_t w;
		for (i = 0; i < line_buf.size(); i++)
			send_char(line_buf[i]);
		send_char(CH_NUL);
		if (typed_kind != PREDICTED) begin
			w.kind   = typed_kind[3:0];
			w.at     = typed_at;
			w.tchar  = 8'h00;
			w.tvalid = 1'b0;
			w.last   = 1'b1;
			void'(expected_words.pop_back());
			expected_words.push_back(w);
		end
		lines_sent++;
	endtask

	// sender goes quiet until the block has delivered everything owed
	task automatic wait_all_delivered();
		chars.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_words.size() != 0);
	endtask

	task automatic add_gaps(input int n);
		repeat (n)
			line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endtask

	// keyword spelling with random letter case
	task automatic add_mixed(input string s);
		int i;
		logic [7:0] c;
		for (i = 0; i < s.len(); i++) begin
			c = s[i];
			if (fold_case(c) >= 8'h41 && fold_case(c) <= 8'h5A && $urandom_range(0, 1))
				c = c ^ 8'h20;
			line_buf.push_back(c);
		end
	endtask

	// printable text with the odd gap, colons included
	task automatic add_word(input int n);
		repeat (n) begin
			if ($urandom_range(0, 15) == 0)
				add_gaps(1);
			else
				line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
		end
	endtask

	// any non-zero byte
	task automatic add_noise(input int n);
		repeat (n)
			line_buf.push_back(8'($urandom_range(1, 255)));
	endtask

	// mostly well-formed lines with random content, some noise and broken keywords
	task automatic build_random_line();
		int form;
		string s;
		line_buf.delete();
		add_gaps($urandom_range(0, 2));
		if ($urandom_range(0, 2) == 0) begin
			line_buf.push_back(CH_AT);
			// a second '@' turns the line into a command
			if ($urandom_range(0, 9) == 0)
				line_buf.push_back(CH_AT);
			add_gaps($urandom_range(0, 2));
		end
		form = $urandom_range(0, 11);
		case (form)
			0: ;
			1, 2: begin
				line_buf.push_back(CH_COLON);
				add_word($urandom_range(0, 20));
			end
			3: begin
				add_mixed("ECHO");
				add_gaps($urandom_range(1, 2));
				case ($urandom_range(0, 3))
					0: add_mixed("OFF");
					1: add_mixed("ON");
					2: add_mixed("OF");
					default: add_mixed("ONE");
				endcase
				if ($urandom_range(0, 3) == 0)
					add_gaps(1);
			end
			4: begin
				add_mixed("ECHO");
				if ($urandom_range(0, 4) != 0)
					add_gaps($urandom_range(1, 2));
				add_word(($urandom_range(0, 5) == 0) ? $urandom_range(60, 75)
					: $urandom_range(0, 12));
			end
			5: begin
				add_mixed("GOTO");
				add_gaps($urandom_range(1, 2));
				if ($urandom_range(0, 1))
					line_buf.push_back(CH_COLON);
				add_word($urandom_range(0, 20));
			end
			6, 7: begin
				add_mixed(kw_spelling($urandom_range(0, 7)));
				if ($urandom_range(0, 2) != 0) begin
					add_gaps(1);
					add_word($urandom_range(0, 8));
				end
			end
			8: begin
				// keyword cut short or run on
				s = kw_spelling($urandom_range(0, 7));
				if ($urandom_range(0, 1)) begin
					add_mixed(s.substr(0, s.len() - 2));
				end else begin
					add_mixed(s);
					line_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
				end
			end
			9, 10: add_word($urandom_range(1, 12));
			default: add_noise($urandom_range(1, 15));
		endcase
	endtask

	// ---------------------------------------------------------------
	// receiver side: ready follows a pattern of its own, plus one long hold-off
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served   <= hold_requests;
			hold_left     <= LONG_HOLD;
			results.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			results.ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      <= rx_mode_t'($urandom_range(0, 3));
				rx_mode_left <= $urandom_range(10, 120);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				RX_OPEN:  results.ready <= 1'b1;
				RX_LIGHT: results.ready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: results.ready <= ($urandom_range(0, 3) == 0);
				default:  results.ready <= (rx_mode_left[1:0] == 2'd0);
			endcase
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at word %0d: %s", words_checked, msg);
		mismatches++;
	endtask

	// every taken result word is held against the oldest one owed
	line_word_t want;
	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("word with nothing owed, kind %0d", results.kind));
			end else begin
				want = expected_words.pop_front();
				if (results.kind != want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", results.kind, want.kind));
				if (results.suppressed != want.at)
					report_mismatch($sformatf("suppressed %0b, want %0b",
						results.suppressed, want.at));
				if (results.text_char != want.tchar)
					report_mismatch($sformatf("text_char %02h, want %02h",
						results.text_char, want.tchar));
				if (results.text_valid != want.tvalid)
					report_mismatch($sformatf("text_valid %0b, want %0b",
						results.text_valid, want.tvalid));
				if (results.last_of_run != want.last)
					report_mismatch($sformatf("last_of_run %0b, want %0b",
						results.last_of_run, want.last));
			end
			kinds_seen[results.kind] <= 1'b1;
			words_checked++;
		end
	end

	// ---------------------------------------------------------------
	// run: reset, directed table, random lines, drain, verdict
	// ---------------------------------------------------------------
	initial begin
		int row;
		int i;
		int directed_chars;
		int random_lines;
		string line_text;
		arst_n        = 1'b0;
		chars.valid   = 1'b0;
		chars.ch      = CH_NUL;
		clear_scan();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		for (row = 0; row < DIR_ROWS; row++) begin
			line_text = dir_text[row];
			line_buf.delete();
			for (i = 0; i < line_text.len(); i++)
				line_buf.push_back(line_text[i]);
			send_line(dir_kind[row], dir_at[row]);
		end
		wait_all_delivered();
		directed_chars = chars_sent;

		// random part
		random_lines = 0;
		while (chars_sent - directed_chars < RANDOM_CHARS) begin
			build_random_line();
			// receiver stops taking words for a long stretch while lines keep coming
			if (random_lines == 0)
				hold_requests <= hold_requests + 1;
			// once mid-run the sender waits for the block to empty out
			if (random_lines == 2)
				wait_all_delivered();
			send_line(PREDICTED, 1'b0);
			random_lines++;
		end

		wait_all_delivered();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d lines (%0d characters), checked %0d result words",
			lines_sent, chars_sent, words_checked);
		$display("line kinds seen: %0d of 13, with random stalls on both sides",
			$countones(kinds_seen));
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_NS);
		$display("timeout with %0d words still owed", expected_words.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
